// ===== sv/acps_pkg.sv =====
// ============================================================================
// acps_pkg
// Shared types and constants of the AC current and pressure level sampler.
// ============================================================================
`default_nettype none

package acps_pkg;

  // Input item kinds (carried on in_tuser).
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CONV = 1'b1;

  // Conversion channel requested next.
  localparam logic [1:0] CH_NONE  = 2'd0;
  localparam logic [1:0] CH_REF   = 2'd1;
  localparam logic [1:0] CH_SENSE = 2'd2;
  localparam logic [1:0] CH_PRESS = 2'd3;

  // Which level an item has just refreshed.
  localparam logic [1:0] UPD_NONE  = 2'd0;
  localparam logic [1:0] UPD_CUR   = 2'd1;
  localparam logic [1:0] UPD_PRESS = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PRESS_SAMPLES = 2'd0;
  localparam logic [1:0] REG_CUR_CONVS     = 2'd1;
  localparam logic [1:0] REG_PRESS_GAIN    = 2'd2;
  localparam logic [1:0] REG_CUR_GAIN      = 2'd3;

  // Field widths.
  localparam int COUNT_W = 8;
  localparam int GAIN_W  = 24;
  localparam int LEVEL_W = 8;
  localparam int CFG_W   = 24;

  // Configuration reset values.
  localparam logic [COUNT_W-1:0] PRESS_SAMPLES_RST = 8'd64;
  localparam logic [COUNT_W-1:0] CUR_CONVS_RST     = 8'd160;
  localparam logic [GAIN_W-1:0]  PRESS_GAIN_RST    = 24'd118787;
  localparam logic [GAIN_W-1:0]  CUR_GAIN_RST      = 24'd129324;

  // Control word passed from the state-update stage to the scaling stage.
  typedef struct packed {
    logic [1:0] next_channel;
    logic [1:0] level_updated;
  } stage_t;

endpackage

`default_nettype wire

// ===== sv/acps_ctrl.sv =====
// ============================================================================
// acps_ctrl
// Phase sequencer and accumulator: takes one item per cycle while the scaling
// stage is not stalled, updates the phase state and running sum, and registers
// the control word for scaling.
`default_nettype none

module acps_ctrl #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               op,
  input  wire logic [SAMPLE_BITS-1:0]             sample,
  input  wire logic [acps_pkg::COUNT_W-1:0]       press_limit,
  input  wire logic [acps_pkg::COUNT_W-1:0]       cur_limit,
  input  wire logic                               down_ready,
  output logic                                    st_valid_r,
  output acps_pkg::stage_t                        st_r,
  output logic [SAMPLE_BITS+7:0]                  st_sum_r
);

  localparam int SUM_W = SAMPLE_BITS + 8;
  localparam logic [acps_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  logic                          in_cur_r, in_cur_nxt;
  logic                          exp_sense_r, exp_sense_nxt;
  logic                          active_r, active_nxt;
  logic [acps_pkg::COUNT_W-1:0]  count_r, count_nxt, count_inc;
  logic [SUM_W-1:0]              sum_r, sum_nxt, sum_added, scale_sum;
  logic [SAMPLE_BITS-1:0]        ref_r, ref_nxt, diff, addend;
  logic [SUM_W:0]                sum_wide;
  acps_pkg::stage_t              st_nxt;
  logic                          accept;

  // The stage register frees up whenever the scaling stage moves on.
  assign in_ready = !st_valid_r || down_ready;
  assign accept   = in_valid && in_ready;

  // Saturating count, absolute difference and saturating sum.
  assign count_inc = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 1'b1;
  assign diff      = (sample >= ref_r) ? sample - ref_r : ref_r - sample;
  assign addend    = in_cur_r ? diff : sample;
  assign sum_wide  = {1'b0, sum_r} + {{(SUM_W + 1 - SAMPLE_BITS){1'b0}}, addend};
  assign sum_added = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  // Next phase state for one item.
  always_comb begin
    in_cur_nxt           = in_cur_r;
    exp_sense_nxt        = exp_sense_r;
    active_nxt           = active_r;
    count_nxt            = count_r;
    sum_nxt              = sum_r;
    ref_nxt              = ref_r;
    scale_sum            = sum_r;
    st_nxt.next_channel  = acps_pkg::CH_NONE;
    st_nxt.level_updated = acps_pkg::UPD_NONE;
    if (op == acps_pkg::OP_TICK) begin
      in_cur_nxt          = !in_cur_r;
      exp_sense_nxt       = 1'b0;
      active_nxt          = 1'b1;
      count_nxt           = '0;
      sum_nxt             = '0;
      st_nxt.next_channel = in_cur_r ? acps_pkg::CH_PRESS : acps_pkg::CH_REF;
    end else if (active_r) begin
      count_nxt = count_inc;
      if (!in_cur_r) begin
        // Pressure phase: every conversion is summed, the last one included.
        sum_nxt = sum_added;
        if (count_inc == press_limit) begin
          scale_sum            = sum_added;
          active_nxt           = 1'b0;
          st_nxt.level_updated = acps_pkg::UPD_PRESS;
        end else begin
          st_nxt.next_channel = acps_pkg::CH_PRESS;
        end
      end else if (count_inc == cur_limit) begin
        // Current phase ends on this conversion without adding it.
        active_nxt           = 1'b0;
        st_nxt.level_updated = acps_pkg::UPD_CUR;
      end else if (!exp_sense_r) begin
        ref_nxt             = sample;
        exp_sense_nxt       = 1'b1;
        st_nxt.next_channel = acps_pkg::CH_SENSE;
      end else begin
        sum_nxt             = sum_added;
        exp_sense_nxt       = 1'b0;
        st_nxt.next_channel = acps_pkg::CH_REF;
      end
    end
  end

  // Phase state registers and the stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cur_r    <= 1'b0;
      exp_sense_r <= 1'b0;
      active_r    <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      ref_r       <= '0;
      st_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        in_cur_r    <= in_cur_nxt;
        exp_sense_r <= exp_sense_nxt;
        active_r    <= active_nxt;
        count_r     <= count_nxt;
        sum_r       <= sum_nxt;
        ref_r       <= ref_nxt;
      end
      if (in_ready) begin
        st_valid_r <= accept;
      end
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      st_r     <= st_nxt;
      st_sum_r <= scale_sum;
    end
  end

endmodule

`default_nettype wire

// ===== sv/acps_scale.sv =====
// ============================================================================
// acps_scale
// Level scaling and result register: multiplies the phase sum by its gain,
// saturates to eight bits, keeps the latest levels and holds the result item.
// ============================================================================
`default_nettype none

module acps_scale #(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               st_valid,
  input  wire acps_pkg::stage_t                   st,
  input  wire logic [SAMPLE_BITS+7:0]             st_sum,
  input  wire logic [acps_pkg::GAIN_W-1:0]        press_gain,
  input  wire logic [acps_pkg::GAIN_W-1:0]        cur_gain,
  output logic                                    st_ready,
  output logic                                    out_valid_r,
  input  wire logic                               out_ready,
  output logic [1:0]                              out_channel_r,
  output logic [acps_pkg::LEVEL_W-1:0]            out_cur_lvl_r,
  output logic [acps_pkg::LEVEL_W-1:0]            out_press_lvl_r,
  output logic [1:0]                              out_updated_r
);

  localparam int SUM_W  = SAMPLE_BITS + 8;
  localparam int PROD_W = SUM_W + acps_pkg::GAIN_W;

  logic [acps_pkg::GAIN_W-1:0]   gain;
  logic [PROD_W-1:0]             prod, prod_sh;
  logic [acps_pkg::LEVEL_W-1:0]  level;
  logic [acps_pkg::LEVEL_W-1:0]  cur_lvl_r, press_lvl_r, cur_lvl_nxt, press_lvl_nxt;
  logic                          advance;

  // The result register takes a new item when empty or being drained.
  assign st_ready = !out_valid_r || out_ready;
  assign advance  = st_valid && st_ready;

  // One multiply, fixed-point shift and saturation to 255.
  assign gain    = (st.level_updated == acps_pkg::UPD_PRESS) ? press_gain : cur_gain;
  assign prod    = {{acps_pkg::GAIN_W{1'b0}}, st_sum} * {{SUM_W{1'b0}}, gain};
  assign prod_sh = prod >> GAIN_FRAC_BITS;
  assign level   = (|prod_sh[PROD_W-1:acps_pkg::LEVEL_W]) ? '1
                                                          : prod_sh[acps_pkg::LEVEL_W-1:0];

  // Latest levels after this item.
  always_comb begin
    cur_lvl_nxt   = cur_lvl_r;
    press_lvl_nxt = press_lvl_r;
    case (st.level_updated)
      acps_pkg::UPD_CUR:   cur_lvl_nxt   = level;
      acps_pkg::UPD_PRESS: press_lvl_nxt = level;
      default: ;
    endcase
  end

  // Level state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_lvl_r   <= '0;
      press_lvl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        cur_lvl_r   <= cur_lvl_nxt;
        press_lvl_r <= press_lvl_nxt;
      end
      if (st_ready) begin
        out_valid_r <= st_valid;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r   <= st.next_channel;
      out_cur_lvl_r   <= cur_lvl_nxt;
      out_press_lvl_r <= press_lvl_nxt;
      out_updated_r   <= st.level_updated;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ac_current_pressure_sampler.sv =====
// ============================================================================
// ac_current_pressure_sampler
// Alternating pressure/current measurement: sums conversions per phase and
// scales the sum into saturated 8-bit levels at the end of each phase.
// ============================================================================
// A result item follows its accepted input item through the state-update stage,
// registered at the accepting edge, then the gain multiplier into the result
// register.
// Throughput: one item per cycle; the output stage drains while a new item
// enters, so both sides keep moving unless the result side stalls.
// Reset (rst_n low, synchronous): phase state, sum and levels clear to zero,
// configuration registers return to their defaults.
`default_nettype none

module ac_current_pressure_sampler #(
  parameter int SAMPLE_BITS    = 10,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input item channel.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,  // [SAMPLE_BITS-1:0] sample
  input  wire logic                               in_tuser,  // [0] op
  // Result item channel.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] next_channel, [9:2] current_level, [17:10] pressure_level,
  // [19:18] level_updated, [23:20] zero
  output logic [23:0]                             out_tdata,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_addr,
  input  wire logic [acps_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [acps_pkg::COUNT_W-1:0]  press_samples_r, cur_convs_r;
  logic [acps_pkg::GAIN_W-1:0]   press_gain_r, cur_gain_r;
  logic                          st_valid, st_ready;
  acps_pkg::stage_t              st;
  logic [SAMPLE_BITS+7:0]        st_sum;
  logic [1:0]                    out_channel, out_updated;
  logic [acps_pkg::LEVEL_W-1:0]  out_cur_lvl, out_press_lvl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_samples_r <= acps_pkg::PRESS_SAMPLES_RST;
      cur_convs_r     <= acps_pkg::CUR_CONVS_RST;
      press_gain_r    <= acps_pkg::PRESS_GAIN_RST;
      cur_gain_r      <= acps_pkg::CUR_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        acps_pkg::REG_PRESS_SAMPLES: press_samples_r <= cfg_wdata[acps_pkg::COUNT_W-1:0];
        acps_pkg::REG_CUR_CONVS:     cur_convs_r     <= cfg_wdata[acps_pkg::COUNT_W-1:0];
        acps_pkg::REG_PRESS_GAIN:    press_gain_r    <= cfg_wdata[acps_pkg::GAIN_W-1:0];
        acps_pkg::REG_CUR_GAIN:      cur_gain_r      <= cfg_wdata[acps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase sequencer and accumulator.
  acps_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .press_limit (press_samples_r),
    .cur_limit   (cur_convs_r),
    .down_ready  (st_ready),
    .st_valid_r  (st_valid),
    .st_r        (st),
    .st_sum_r    (st_sum)
  );

  // Gain multiply and result register.
  acps_scale #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .st_valid        (st_valid),
    .st              (st),
    .st_sum          (st_sum),
    .press_gain      (press_gain_r),
    .cur_gain        (cur_gain_r),
    .st_ready        (st_ready),
    .out_valid_r     (out_tvalid),
    .out_ready       (out_tready),
    .out_channel_r   (out_channel),
    .out_cur_lvl_r   (out_cur_lvl),
    .out_press_lvl_r (out_press_lvl),
    .out_updated_r   (out_updated)
  );

  // Pack the result item.
  assign out_tdata = {4'b0000, out_updated, out_press_lvl, out_cur_lvl, out_channel};

endmodule

`default_nettype wire
